// ===== rtl/rmv_pkg.sv =====
// rmv_pkg: widths, limits and sequencer states for the running mean and variance block
// no dependencies; imported by the interfaces and by running_mean_variance
package rmv_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COUNT_BITS    = 16;
	localparam int FRACTION_BITS = 16;

	localparam int MEAN_BITS = 32;
	localparam int VAR_BITS  = 47;
	localparam int SD_BITS   = 32;
	localparam int SUM_BITS  = 64;

	// magnitude of a deviation from the mean, x - m spans up to 2^32
	localparam int MAG_BITS  = MEAN_BITS + 1;
	localparam int ALU_BITS  = SUM_BITS + 1;
	localparam int INC_BITS  = 2 * MAG_BITS - FRACTION_BITS;
	localparam int ITER_BITS = $clog2(SUM_BITS + 1);

	localparam int DIV1_STEPS = MAG_BITS;
	localparam int DIV2_STEPS = SUM_BITS;
	localparam int MUL_STEPS  = MAG_BITS;
	localparam int SQRT_STEPS = SUM_BITS / 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_D1,
		S_ABS1,
		S_DIV1,
		S_MEAN,
		S_D2,
		S_ABS2,
		S_MUL,
		S_SUM,
		S_DIV2,
		S_SQRT,
		S_OUT
	} rmv_state_t;

endpackage

// ===== rtl/rmv_sample_if.sv =====
// rmv_sample_if: valid/ready channel carrying one input sample
// depends on rmv_pkg
interface rmv_sample_if import rmv_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/rmv_stats_if.sv =====
// rmv_stats_if: valid/ready channel carrying one set of running statistics
// depends on rmv_pkg
interface rmv_stats_if import rmv_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [COUNT_BITS-1:0]       sample_count;
	logic signed [MEAN_BITS-1:0] mean_value;
	logic [VAR_BITS-1:0]         variance_value;
	logic [SD_BITS-1:0]          std_dev_value;
	logic                        count_full;

	modport source (output valid, output sample_count, output mean_value,
		output variance_value, output std_dev_value, output count_full, input ready);
	modport sink (input valid, input sample_count, input mean_value,
		input variance_value, input std_dev_value, input count_full, output ready);
endinterface

// ===== rtl/running_mean_variance.sv =====
// running_mean_variance: welford update of count, mean and squared deviation sum
// sequence for a normal sample: 33-step mean divide, 33-step multiply, 64-step variance divide,
// 32-step square root, all on one shared 65-bit add/subtract unit; the first sample goes
// straight to the result, and once full only the variance divide and square root run
// one sample in flight at a time; a new sample is taken only after the last result is loaded
// reset: asynchronous, active low; clears count, mean and sum, result channel empty
// depends on rmv_pkg, rmv_sample_if, rmv_stats_if
module running_mean_variance import rmv_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rmv_sample_if.sink  samples,
	rmv_stats_if.source stats
);

	rmv_state_t state_q, state_d;

	logic [COUNT_BITS-1:0]       cnt_q;
	logic [COUNT_BITS-1:0]       nm1_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [SUM_BITS-1:0]         sum_q;
	logic signed [MEAN_BITS-1:0] x_q;
	logic                        full_q;
	logic                        neg_q;
	logic [ALU_BITS-1:0]         t_q;
	logic [SUM_BITS-1:0]         quo_q;
	logic [COUNT_BITS-1:0]       rem_q;
	logic [MAG_BITS-1:0]         m1_q;
	logic [ITER_BITS-1:0]        iter_q;
	logic [VAR_BITS-1:0]         var_q;
	logic [SD_BITS-1:0]          sd_q;

	logic                        out_valid_q;
	logic [COUNT_BITS-1:0]       o_count_q;
	logic signed [MEAN_BITS-1:0] o_mean_q;
	logic [VAR_BITS-1:0]         o_var_q;
	logic [SD_BITS-1:0]          o_sd_q;
	logic                        o_full_q;

	logic [ALU_BITS-1:0]   alu_a, alu_b, alu_y;
	logic                  alu_sub;
	logic [COUNT_BITS-1:0] divisor;
	logic [INC_BITS-1:0]   inc;
	logic [MAG_BITS-1:0]   mag;
	logic [SUM_BITS-1:0]   quo_shift;
	logic [VAR_BITS-1:0]   var_sat;
	logic                  last;
	logic                  in_xfer;
	logic                  out_load;
	logic                  is_full;

	assign alu_y     = alu_a + (alu_b ^ {ALU_BITS{alu_sub}}) + ALU_BITS'(alu_sub);
	assign divisor   = (state_q == S_DIV1) ? cnt_q : nm1_q;
	assign inc       = {t_q[MAG_BITS-1:0], quo_q[SUM_BITS-1 -: INC_BITS-MAG_BITS]};
	assign mag       = neg_q ? alu_y[MAG_BITS-1:0] : t_q[MAG_BITS-1:0];
	assign quo_shift = {quo_q[SUM_BITS-2:0], ~alu_y[ALU_BITS-1]};
	assign var_sat   = (quo_shift[SUM_BITS-1:VAR_BITS] != '0) ? {VAR_BITS{1'b1}}
		: quo_shift[VAR_BITS-1:0];
	assign last      = (iter_q == ITER_BITS'(1));
	assign in_xfer   = samples.valid && samples.ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || stats.ready);
	assign is_full   = (cnt_q == COUNT_MAX);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (samples.valid) begin
					if (is_full) state_d = S_DIV2;
					else if (cnt_q == '0) state_d = S_OUT;
					else state_d = S_D1;
				end
			end
			S_D1:   state_d = S_ABS1;
			S_ABS1: state_d = S_DIV1;
			S_DIV1: if (last) state_d = S_MEAN;
			S_MEAN: state_d = S_D2;
			S_D2:   state_d = S_ABS2;
			S_ABS2: state_d = S_MUL;
			S_MUL:  if (last) state_d = S_SUM;
			S_SUM:  state_d = S_DIV2;
			S_DIV2: if (last) state_d = S_SQRT;
			S_SQRT: if (last) state_d = S_OUT;
			S_OUT:  if (!out_valid_q || stats.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// shared unit operands and handshake
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		samples.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_D1, S_D2: begin
				alu_a   = ALU_BITS'(x_q);
				alu_b   = ALU_BITS'(mean_q);
				alu_sub = 1'b1;
			end
			S_ABS1, S_ABS2: begin
				alu_b   = t_q;
				alu_sub = 1'b1;
			end
			S_DIV1, S_DIV2: begin
				alu_a   = ALU_BITS'({rem_q, quo_q[SUM_BITS-1]});
				alu_b   = ALU_BITS'(divisor);
				alu_sub = 1'b1;
			end
			S_MEAN: begin
				alu_a   = ALU_BITS'(mean_q);
				alu_b   = ALU_BITS'(quo_q[MAG_BITS-1:0]);
				alu_sub = neg_q;
			end
			S_MUL: begin
				alu_a = ALU_BITS'(t_q[MAG_BITS:0]);
				alu_b = quo_q[0] ? ALU_BITS'(m1_q) : '0;
			end
			S_SUM: begin
				alu_a = ALU_BITS'(sum_q);
				alu_b = ALU_BITS'(inc);
			end
			S_SQRT: begin
				alu_a   = ALU_BITS'({t_q[SD_BITS:0], quo_q[SUM_BITS-1 -: 2]});
				alu_b   = ALU_BITS'({sd_q, 2'b01});
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mean_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && !is_full) begin
				cnt_q <= cnt_q + COUNT_BITS'(1);
				if (cnt_q == '0) begin
					mean_q <= {samples.sample, {FRACTION_BITS{1'b0}}};
					sum_q  <= '0;
				end
			end
			if (state_q == S_MEAN) mean_q <= alu_y[MEAN_BITS-1:0];
			if (state_q == S_SUM) sum_q <= alu_y[SUM_BITS] ? '1 : alu_y[SUM_BITS-1:0];
			if (out_load) out_valid_q <= 1'b1;
			else if (stats.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					x_q    <= {samples.sample, {FRACTION_BITS{1'b0}}};
					full_q <= is_full;
					nm1_q  <= is_full ? COUNT_MAX - COUNT_BITS'(1) : cnt_q;
					var_q  <= '0;
					sd_q   <= '0;
					quo_q  <= sum_q;
					rem_q  <= '0;
					iter_q <= ITER_BITS'(DIV2_STEPS);
				end
			end
			S_D1, S_D2: begin
				t_q   <= alu_y;
				neg_q <= alu_y[ALU_BITS-1];
			end
			S_ABS1: begin
				m1_q   <= mag;
				quo_q  <= {mag, {(SUM_BITS-MAG_BITS){1'b0}}};
				rem_q  <= '0;
				iter_q <= ITER_BITS'(DIV1_STEPS);
			end
			S_DIV1, S_DIV2: begin
				rem_q <= alu_y[ALU_BITS-1] ? {rem_q[COUNT_BITS-2:0], quo_q[SUM_BITS-1]}
					: alu_y[COUNT_BITS-1:0];
				if (state_q == S_DIV2 && last) begin
					var_q  <= var_sat;
					quo_q  <= SUM_BITS'(var_sat) << FRACTION_BITS;
					t_q    <= '0;
					sd_q   <= '0;
					iter_q <= ITER_BITS'(SQRT_STEPS);
				end else begin
					quo_q  <= quo_shift;
					iter_q <= iter_q - ITER_BITS'(1);
				end
			end
			S_ABS2: begin
				quo_q  <= SUM_BITS'(mag);
				t_q    <= '0;
				iter_q <= ITER_BITS'(MUL_STEPS);
			end
			S_MUL: begin
				t_q    <= ALU_BITS'(alu_y[MAG_BITS+1:1]);
				quo_q  <= {alu_y[0], quo_q[SUM_BITS-1:1]};
				iter_q <= iter_q - ITER_BITS'(1);
			end
			S_SUM: begin
				quo_q  <= alu_y[SUM_BITS] ? '1 : alu_y[SUM_BITS-1:0];
				rem_q  <= '0;
				iter_q <= ITER_BITS'(DIV2_STEPS);
			end
			S_SQRT: begin
				quo_q  <= {quo_q[SUM_BITS-3:0], 2'b00};
				iter_q <= iter_q - ITER_BITS'(1);
				if (alu_y[ALU_BITS-1]) begin
					t_q  <= ALU_BITS'({t_q[SD_BITS:0], quo_q[SUM_BITS-1 -: 2]});
					sd_q <= {sd_q[SD_BITS-2:0], 1'b0};
				end else begin
					t_q  <= alu_y;
					sd_q <= {sd_q[SD_BITS-2:0], 1'b1};
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_count_q <= cnt_q;
			o_mean_q  <= mean_q;
			o_var_q   <= var_q;
			o_sd_q    <= sd_q;
			o_full_q  <= full_q;
		end
	end

	assign stats.valid          = out_valid_q;
	assign stats.sample_count   = o_count_q;
	assign stats.mean_value     = o_mean_q;
	assign stats.variance_value = o_var_q;
	assign stats.std_dev_value  = o_sd_q;
	assign stats.count_full     = o_full_q;

endmodule

// ===== sim/rmv_stats_checker.sv =====
`timescale 1ns / 1ps
// rmv_stats_checker: watches both channels of running_mean_variance, predicts each set of
// statistics with a fixed point welford update and compares it field by field
// depends on rmv_pkg, rmv_sample_if, rmv_stats_if
module rmv_stats_checker import rmv_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	rmv_sample_if samples,
	rmv_stats_if  stats,
	output int    failures,
	output int    results_due
);

	typedef struct packed {
		logic [COUNT_BITS-1:0]       sample_count;
		logic signed [MEAN_BITS-1:0] mean_value;
		logic [VAR_BITS-1:0]         variance_value;
		logic [SD_BITS-1:0]          std_dev_value;
		logic                        count_full;
	} stats_t;

	localparam longint      MEAN_TOP    = (longint'(1) << (MEAN_BITS - 1)) - 1;
	localparam longint      MEAN_BOTTOM = -(longint'(1) << (MEAN_BITS - 1));
	localparam logic [63:0] VAR_LIMIT   = (64'd1 << VAR_BITS) - 64'd1;
	localparam logic [63:0] SD_LIMIT    = (64'd1 << SD_BITS) - 64'd1;
	localparam logic [63:0] SUM_LIMIT   = {64{1'b1}};

	logic [COUNT_BITS-1:0] taken;
	longint                mean_acc;
	logic [63:0]           dev_sum;
	stats_t                stats_due [$];
	int                    mismatches;

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// floor(a * b / 2^FRACTION_BITS), saturated to 64 bits
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> FRACTION_BITS;
		if (p[127:64] != '0)
			return SUM_LIMIT;
		return p[63:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] probe;
		root = '0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != '0) begin
			if (v >= root + probe) begin
				v = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	task automatic welford_update(input logic signed [SAMPLE_BITS-1:0] s, output stats_t r);
		longint      x;
		longint      d1;
		longint      d2;
		longint      next_mean;
		logic [63:0] inc;
		logic [63:0] span;
		logic [63:0] var_q;
		logic [63:0] sd;
		logic        saturated;
		saturated = (taken == COUNT_MAX);
		var_q = '0;
		sd = '0;
		if (!saturated) begin
			x = longint'(s) * (longint'(1) << FRACTION_BITS);
			taken = taken + COUNT_BITS'(1);
			if (taken == 1) begin
				mean_acc = x;
				dev_sum = '0;
			end else begin
				d1 = x - mean_acc;
				next_mean = mean_acc + d1 / longint'(taken);
				d2 = x - next_mean;
				inc = scaled_product(magnitude(d1), magnitude(d2));
				dev_sum = (dev_sum > ~inc) ? SUM_LIMIT : dev_sum + inc;
				mean_acc = next_mean;
			end
			if (mean_acc > MEAN_TOP)
				mean_acc = MEAN_TOP;
			if (mean_acc < MEAN_BOTTOM)
				mean_acc = MEAN_BOTTOM;
		end
		if (taken >= 2) begin
			span = 64'(taken) - 64'd1;
			var_q = dev_sum / span;
			if (var_q > VAR_LIMIT)
				var_q = VAR_LIMIT;
			if (var_q > (SUM_LIMIT >> FRACTION_BITS))
				sd = SD_LIMIT;
			else
				sd = floor_sqrt(var_q << FRACTION_BITS);
			if (sd > SD_LIMIT)
				sd = SD_LIMIT;
		end
		r.sample_count = taken;
		r.mean_value = mean_acc[MEAN_BITS-1:0];
		r.variance_value = var_q[VAR_BITS-1:0];
		r.std_dev_value = sd[SD_BITS-1:0];
		r.count_full = saturated;
	endtask

	task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		stats_t got;
		if (!arst_n) begin
			taken = '0;
			mean_acc = 0;
			dev_sum = '0;
			stats_due.delete();
			mismatches = 0;
			failures <= 0;
			results_due <= 0;
		end else begin
			if (stats.valid && stats.ready) begin
				got.sample_count = stats.sample_count;
				got.mean_value = stats.mean_value;
				got.variance_value = stats.variance_value;
				got.std_dev_value = stats.std_dev_value;
				got.count_full = stats.count_full;
				if (stats_due.size() == 0) begin
					$display("%0t: statistics transfer with nothing expected, count %0h",
						$time, got.sample_count);
					mismatches++;
				end else begin
					want = stats_due.pop_front();
					if (got.sample_count !== want.sample_count)
						flag_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
					if (got.mean_value !== want.mean_value)
						flag_field("mean_value", 64'(unsigned'(want.mean_value)),
							64'(unsigned'(got.mean_value)));
					if (got.variance_value !== want.variance_value)
						flag_field("variance_value", 64'(want.variance_value),
							64'(got.variance_value));
					if (got.std_dev_value !== want.std_dev_value)
						flag_field("std_dev_value", 64'(want.std_dev_value), 64'(got.std_dev_value));
					if (got.count_full !== want.count_full)
						flag_field("count_full", 64'(want.count_full), 64'(got.count_full));
				end
			end
			if (samples.valid && samples.ready) begin
				welford_update(samples.sample, want);
				stats_due.push_back(want);
			end
			failures <= mismatches;
			results_due <= stats_due.size();
		end
	end

endmodule

// ===== sim/tb_running_mean_variance.sv =====
`timescale 1ns / 1ps
// tb_running_mean_variance: drives samples into running_mean_variance under changing idle
// patterns and a long output hold-off, and reports the verdict of rmv_stats_checker
// depends on rmv_pkg, rmv_sample_if, rmv_stats_if, running_mean_variance, rmv_stats_checker
module tb_running_mean_variance;
	import rmv_pkg::*;

	localparam int OPENING_SAMPLES = 20;
	localparam int RANDOM_SAMPLES  = 1500;
	localparam int TOTAL_SAMPLES   = OPENING_SAMPLES + RANDOM_SAMPLES;
	localparam int HOLD_AT         = 60;
	localparam int HOLD_CYCLES     = 1200;
	localparam int SETTLE_CYCLES   = 400;
	localparam int STALL_LIMIT     = 20000;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   results_due;
	int   take_idle_pct;
	logic hold_request;

	rmv_sample_if samples_ch ();
	rmv_stats_if  stats_ch ();

	running_mean_variance dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.stats   (stats_ch)
	);

	rmv_stats_checker stats_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_ch),
		.stats       (stats_ch),
		.failures    (failures),
		.results_due (results_due)
	);

	always #5 clk = ~clk;

	task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] value, input int gap_pct);
		if (gap_pct > 0 && $urandom_range(0, 99) < 4) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 250)) @(posedge clk);
		end
		while ($urandom_range(0, 99) < gap_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.sample <= value;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
	endtask

	// receiver side, with one long hold-off so the block backs up
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		stats_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stats_ch.ready <= 1'b0;
			end else begin
				stats_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples_ch.valid && samples_ch.ready) || (stats_ch.valid && stats_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_running_mean_variance: done, errors");
		$finish;
	end

	initial begin
		logic signed [SAMPLE_BITS-1:0] opening [OPENING_SAMPLES];
		logic signed [SAMPLE_BITS-1:0] pick;
		logic signed [SAMPLE_BITS-1:0] last_pick;
		logic signed [SAMPLE_BITS-1:0] cluster_base;
		int roll;
		int gap_pct;
		opening = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
			16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h3039,
			16'hCFC7, 16'h0000, 16'h0000, 16'h00FF, 16'hFF00};
		arst_n <= 1'b0;
		samples_ch.valid <= 1'b0;
		samples_ch.sample <= '0;
		take_idle_pct <= 82;
		hold_request <= 1'b0;
		gap_pct = 38;
		last_pick = '0;
		cluster_base = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < TOTAL_SAMPLES; i++) begin
			if (i == TOTAL_SAMPLES / 3) begin
				gap_pct = 82;
				take_idle_pct <= 38;
			end
			if (i == 2 * TOTAL_SAMPLES / 3) begin
				gap_pct = 0;
				take_idle_pct <= 0;
			end
			if (i == HOLD_AT)
				hold_request <= 1'b1;
			if (i < OPENING_SAMPLES) begin
				pick = opening[i];
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					pick = SAMPLE_BITS'($urandom_range(0, 65535));
				end else if (roll < 65) begin
					case ($urandom_range(0, 3))
						0: pick = SAMPLE_TOP;
						1: pick = SAMPLE_BOTTOM;
						2: pick = '0;
						default: pick = '1;
					endcase
				end else if (roll < 90) begin
					// tight clusters keep the variance small
					if ($urandom_range(0, 15) == 0)
						cluster_base = SAMPLE_BITS'($urandom_range(0, 65535));
					pick = SAMPLE_BITS'(cluster_base + $urandom_range(0, 15) - 8);
				end else begin
					pick = last_pick;
				end
			end
			last_pick = pick;
			offer_sample(pick, gap_pct);
		end
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_running_mean_variance: done, clean");
		else
			$display("tb_running_mean_variance: done, errors");
		$finish;
	end

endmodule

// ===== running_mean_variance.f =====
rtl/rmv_pkg.sv
rtl/rmv_sample_if.sv
rtl/rmv_stats_if.sv
rtl/running_mean_variance.sv
sim/rmv_stats_checker.sv
sim/tb_running_mean_variance.sv
